### sv/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg
// Types and codes shared by the ordered list controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package iol_pkg;

  // operation codes
  localparam logic [2:0] OP_READ   = 3'd0;
  localparam logic [2:0] OP_HEAD   = 3'd1;
  localparam logic [2:0] OP_TAIL   = 3'd2;
  localparam logic [2:0] OP_AT     = 3'd3;
  localparam logic [2:0] OP_DELETE = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned POS_W = 7;
  localparam int unsigned VAL_W = 32;

  // what the latched request still has to do
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_READ = 2'd1,
    MODE_INS  = 2'd2,
    MODE_DEL  = 2'd3
  } mode_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch request and classify it
    logic rd;     // issue memory read
    logic step;   // consume read data
    logic fin;    // finish request, present result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  more;      // another shift step is needed
    logic  out_free;  // result register can take a new result
  } stat_t;

endpackage
`default_nettype wire

### sv/iol_ctrl.sv
// ----------------------------------------------------------------------------
// iol_ctrl
// Sequencer: decode, shift loop over the entry memory, then finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module iol_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_tvalid,
  output logic           in_tready,
  input  iol_pkg::stat_t stat,
  output iol_pkg::cmd_t  cmd
);
  import iol_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_RD   = 5'b00100,
    S_WR   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (stat.mode)
          MODE_READ: state_nxt = S_RD;
          MODE_INS,
          MODE_DEL:  state_nxt = stat.more ? S_RD : S_FIN;
          default:   state_nxt = S_FIN;
        endcase
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.step  = 1'b1;
        state_nxt = (stat.mode == MODE_READ) ? S_FIN : S_DEC;
      end
      S_FIN: begin
        // hold the finished request until the result register is free
        if (stat.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/iol_datapath.sv
// ----------------------------------------------------------------------------
// iol_datapath
// Entry memory, count, shift index and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module iol_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  iol_pkg::cmd_t                cmd,
  output iol_pkg::stat_t               stat,
  input  wire [2:0]                    req_op,
  input  wire [iol_pkg::POS_W-1:0]     req_pos,
  input  wire signed [iol_pkg::VAL_W-1:0] req_val,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [iol_pkg::VAL_W-1:0] out_value,
  output logic [1:0]                   out_status,
  output logic [iol_pkg::POS_W-1:0]    out_count
);
  import iol_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned EW = (CW > POS_W) ? CW : POS_W;
  localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] rdata_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           idx_r;
  logic [CW-1:0]           tgt_r;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] rd_r;
  logic [1:0]              st_r;
  mode_t                   mode_r;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [1:0]              out_status_r;
  logic [CW-1:0]           out_count_r;

  logic [EW-1:0] pos_e, cnt_e;
  logic          full;
  mode_t         mode_nxt;
  logic [1:0]    st_nxt;
  logic [CW-1:0] tgt_nxt;
  logic [CW-1:0] raddr;

  assign pos_e = EW'(req_pos);
  assign cnt_e = EW'(count_r);
  assign full  = (cnt_e >= CAP_E);

  // classify a new request against the current count
  always_comb begin
    mode_nxt = MODE_NONE;
    st_nxt   = ST_DONE;
    tgt_nxt  = '0;
    unique case (req_op)
      OP_READ: begin
        if (pos_e < cnt_e) mode_nxt = MODE_READ;
        else               st_nxt   = ST_RANGE;
        tgt_nxt = CW'(req_pos);
      end
      OP_HEAD: begin
        if (full) st_nxt = ST_FULL;
        else      mode_nxt = MODE_INS;
      end
      OP_TAIL: begin
        if (full) st_nxt = ST_FULL;
        else      mode_nxt = MODE_INS;
        tgt_nxt = count_r;
      end
      OP_AT: begin
        priority if (pos_e > cnt_e) st_nxt = ST_RANGE;
        else if (full)              st_nxt = ST_FULL;
        else                        mode_nxt = MODE_INS;
        tgt_nxt = CW'(req_pos);
      end
      OP_DELETE: begin
        if (pos_e >= cnt_e) st_nxt = ST_RANGE;
        else                mode_nxt = MODE_DEL;
        tgt_nxt = CW'(req_pos);
      end
      default: ;
    endcase
  end

  // read address follows the shift direction
  always_comb begin
    unique case (mode_r)
      MODE_INS: raddr = idx_r - CW'(1);
      MODE_DEL: raddr = idx_r + CW'(1);
      default:  raddr = idx_r;
    endcase
  end

  assign stat.mode     = mode_r;
  assign stat.more     = (mode_r == MODE_INS) ? (idx_r > tgt_r)
                                              : ((idx_r + CW'(1)) < count_r);
  assign stat.out_free = !out_valid_r || out_ready;

  // request registers and shift index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_nxt;
      st_r   <= st_nxt;
      tgt_r  <= tgt_nxt;
      val_r  <= req_val;
      rd_r   <= (st_nxt == ST_RANGE && req_op == OP_READ) ? -32'sd1 : 32'sd0;
      idx_r  <= (mode_nxt == MODE_INS) ? count_r : tgt_nxt;
    end else if (cmd.step) begin
      unique case (mode_r)
        MODE_READ: rd_r  <= rdata_r;
        MODE_INS:  idx_r <= idx_r - CW'(1);
        MODE_DEL:  idx_r <= idx_r + CW'(1);
        default: ;
      endcase
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[raddr[AW-1:0]];
    end
    if (cmd.step && (mode_r == MODE_INS || mode_r == MODE_DEL)) begin
      mem[idx_r[AW-1:0]] <= rdata_r;
    end else if (cmd.fin && mode_r == MODE_INS) begin
      mem[tgt_r[AW-1:0]] <= val_r;
    end
  end

  // count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin && mode_r == MODE_INS) count_r <= count_r + CW'(1);
      if (cmd.fin && mode_r == MODE_DEL) count_r <= count_r - CW'(1);
      if (cmd.fin)            out_valid_r <= 1'b1;
      else if (out_ready)     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_value_r  <= rd_r;
      out_status_r <= st_r;
      unique case (mode_r)
        MODE_INS: out_count_r <= count_r + CW'(1);
        MODE_DEL: out_count_r <= count_r - CW'(1);
        default:  out_count_r <= count_r;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = POS_W'(out_count_r);

`ifndef SYNTH
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (EW'(count_r) <= CAP_E)) else $error("count above capacity");
  a_count_fin: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.fin |=> (count_r == $past(count_r))) else $error("count moved outside finish");
  a_count_rej: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && st_r != ST_DONE) |=> (count_r == $past(count_r)))
    else $error("rejected request changed count");
  a_res_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> (out_count_r == count_r)) else $error("result count mismatch");
`endif

endmodule
`default_nettype wire

### sv/indexed_ordered_list.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list
// Bounded ordered list of signed 32-bit values with positional requests.
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser
// in       in   [6:0] position, [38:7] value   [2:0] operation
// out      out  [31:0] read_value, [38:32] cnt [1:0] status
//
// Read: decode, read, take the data, finish. Insert and delete: the shift
// loop moves one entry per pass over the single-port entry memory (decide,
// read, then write back one place along). Rejected requests: decode, finish.
// Synchronous active-low reset clears the count; entries need no clearing.
// A new request is taken whenever the sequencer is idle; the finish step
// waits while the result register still holds an unaccepted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module indexed_ordered_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [39:0] in_tdata,   // position[6:0], value[38:7]
  input  wire  [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // read_value[31:0], entry_count[38:32]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import iol_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic signed [VAL_W-1:0] res_value;
  logic [POS_W-1:0]        res_count;

  iol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  iol_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .req_op     (in_tuser),
    .req_pos    (in_tdata[6:0]),
    .req_val    (in_tdata[38:7]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_value  (res_value),
    .out_status (out_tuser),
    .out_count  (res_count)
  );

  assign out_tdata = {1'b0, res_count, res_value};

endmodule
`default_nettype wire

### sim/indexed_ordered_list_checker.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list_checker
// Watches both channels of the ordered list, keeps its own copy of the list,
// predicts each result and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module indexed_ordered_list_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [39:0] in_tdata,
  input  wire  [2:0]  in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [39:0] out_tdata,
  input  wire  [1:0]  out_tuser,
  output int          fail_count,
  output int          pending
);
  import iol_pkg::*;

  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [6:0]  entry_count;
  } list_result_t;

  logic [31:0]  shadow_list[$];
  list_result_t awaited[$];

  // work out the result of one request and update the shadow list
  function automatic list_result_t apply_request(logic [2:0] op, logic [6:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    r.read_value = '0;
    r.status     = ST_DONE;
    case (op)
      OP_READ: begin
        if (pos < shadow_list.size()) r.read_value = shadow_list[pos];
        else begin
          r.read_value = '1;
          r.status     = ST_RANGE;
        end
      end
      OP_HEAD: begin
        if (shadow_list.size() >= CAPACITY) r.status = ST_FULL;
        else shadow_list.push_front(val);
      end
      OP_TAIL: begin
        if (shadow_list.size() >= CAPACITY) r.status = ST_FULL;
        else shadow_list.push_back(val);
      end
      OP_AT: begin
        if (pos > shadow_list.size()) r.status = ST_RANGE;
        else if (shadow_list.size() >= CAPACITY) r.status = ST_FULL;
        else shadow_list.insert(pos, val);
      end
      OP_DELETE: begin
        if (pos >= shadow_list.size()) r.status = ST_RANGE;
        else shadow_list.delete(pos);
      end
      default: ;
    endcase
    r.entry_count = 7'(shadow_list.size());
    return r;
  endfunction

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      shadow_list.delete();
      awaited.delete();
    end else begin
      if (in_tvalid && in_tready)
        awaited.push_back(apply_request(in_tuser, in_tdata[6:0], in_tdata[38:7]));
      if (out_tvalid && out_tready) begin
        if (awaited.size() == 0) begin
          $display("%0t: result with no request waiting: got %h/%0d/%0d", $time,
                   out_tdata[31:0], out_tuser, out_tdata[38:32]);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (want.read_value !== out_tdata[31:0]) begin
            $display("%0t: read_value expected %h actual %h", $time,
                     want.read_value, out_tdata[31:0]);
            fail_count++;
          end
          if (want.status !== out_tuser) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_tuser);
            fail_count++;
          end
          if (want.entry_count !== out_tdata[38:32]) begin
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     want.entry_count, out_tdata[38:32]);
            fail_count++;
          end
        end
      end
    end
    pending = awaited.size();
  end

endmodule
`default_nettype wire

### sim/indexed_ordered_list_test.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list_test
// Drives list requests, directed then random, with random gaps and stalls on
// both sides; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module indexed_ordered_list_test;
  import iol_pkg::*;

  localparam int unsigned CAPACITY = 64;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // position[6:0], value[38:7]
  logic [2:0]  in_tuser;   // operation[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // read_value[31:0], entry_count[38:32]
  logic [1:0]  out_tuser;  // status[1:0]
  int          fail_count;
  int          pending;

  int  sent_count;     // driver's view of the list length
  bit  gaps_on;
  bit  long_hold;

  indexed_ordered_list #(.CAPACITY(CAPACITY)) dut (.*);

  indexed_ordered_list_checker #(.CAPACITY(CAPACITY)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit: every request at its longest shift plus stalls, many times over
  initial begin
    #20_000_000;
    $display("indexed_ordered_list_test: done, errors");
    $finish;
  end

  // one request: hold until taken, then maybe a random gap
  task automatic send_request(logic [2:0] op, logic [6:0] pos, logic [31:0] val);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, val, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (op)
      OP_HEAD, OP_TAIL: if (sent_count < CAPACITY) sent_count++;
      OP_AT:     if (pos <= sent_count && sent_count < CAPACITY) sent_count++;
      OP_DELETE: if (pos < sent_count) sent_count--;
      default: ;
    endcase
    if (gaps_on && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  // position mostly inside the list, sometimes just past or far past its end
  function automatic logic [6:0] pick_pos(bit can_append);
    int unsigned k = $urandom_range(9);
    if (k == 0) return 7'($urandom_range(127));
    if (k == 1 || sent_count == 0) return 7'(sent_count + (can_append ? 0 : 0));
    return 7'($urandom_range(can_append ? sent_count : sent_count - 1));
  endfunction

  // receiver: random stalls, one long hold-off, none in the last part
  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (gaps_on && $urandom_range(3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(8, 1)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [2:0] op;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_READ;
    sent_count = 0;
    gaps_on    = 1'b1;
    long_hold  = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list corners, extremes, every operation
    send_request(OP_READ, 7'd0, '0);
    send_request(OP_DELETE, 7'd0, '0);
    send_request(OP_AT, 7'd1, 32'h1234_5678);
    send_request(OP_AT, 7'd0, 32'h8000_0000);
    send_request(OP_DELETE, 7'd0, '0);             // last entry removed
    send_request(OP_READ, 7'd0, '0);
    send_request(OP_HEAD, 7'd0, 32'h7FFF_FFFF);
    send_request(OP_TAIL, 7'd127, 32'hFFFF_FFFF);
    send_request(OP_HEAD, 7'd0, 32'h0000_0000);
    send_request(OP_AT, 7'd3, 32'hA5A5_A5A5);      // append via insert-at
    send_request(OP_AT, 7'd1, 32'h5A5A_5A5A);
    send_request(OP_READ, 7'd4, '0);
    send_request(OP_READ, 7'd5, '0);
    send_request(OP_READ, 7'd127, '0);
    send_request(OP_DELETE, 7'd127, '0);
    send_request(3'd5, 7'd0, 32'hFFFF_FFFF);
    send_request(3'd6, 7'd127, '0);
    send_request(3'd7, 7'd64, '0);
    // fill to capacity, then every insert kind against a full store
    while (sent_count < CAPACITY) send_request(OP_TAIL, 7'($urandom_range(127)), $urandom);
    send_request(OP_HEAD, 7'd0, $urandom);
    send_request(OP_TAIL, 7'd0, $urandom);
    send_request(OP_AT, 7'd64, $urandom);
    send_request(OP_AT, 7'd65, $urandom);
    send_request(OP_READ, 7'd63, '0);
    send_request(OP_DELETE, 7'd63, '0);

    // sender pauses until the block has drained
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // receiver holds off while requests keep coming
    long_hold = 1'b1;
    for (int i = 0; i < 860; i++) begin
      if (i == 720) gaps_on = 1'b0;
      op = 3'($urandom_range(9) < 9 ? $urandom_range(4) : $urandom_range(7, 5));
      // steer the length: favour deletes when long, inserts when short
      if (sent_count > 48 && $urandom_range(2) == 0) op = OP_DELETE;
      if (sent_count < 4 && $urandom_range(1) == 0) op = OP_TAIL;
      send_request(op, pick_pos(op == OP_AT), $urandom);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("indexed_ordered_list_test: done, clean");
    else $display("indexed_ordered_list_test: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
